>>> rtl/fwsm_pkg.sv
// ----------------------------------------------------------------------------
// fwsm_pkg
// Shared types and constants of the four-wheel steering mixer.
// ----------------------------------------------------------------------------
package fwsm_pkg;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQA  = 9'b000000010,
        S_SQB  = 9'b000000100,
        S_ROOT = 9'b000001000,
        S_RND  = 9'b000010000,
        S_SPD  = 9'b000100000,
        S_YAW  = 9'b001000000,
        S_ROT  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        MODE_CRAB   = 4'b0001,
        MODE_STEER  = 4'b0010,
        MODE_ROTATE = 4'b0100,
        MODE_HOLD   = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        REG_ANGLE_LIMIT = 2'd0,
        REG_SPEED_GAIN  = 2'd1,
        REG_WHEEL_BASE  = 2'd2,
        REG_JOYPAD_HOLD = 2'd3
    } reg_idx_t;

    localparam int unsigned CORDIC_ITERS = 28;
    localparam logic signed [17:0] ANGLE_MAX = 18'sd12868;

    localparam logic [13:0] ANGLE_LIMIT_RST = 14'd6554;
    localparam logic [15:0] SPEED_GAIN_RST  = 16'd4096;
    localparam logic [15:0] WHEEL_BASE_RST  = 16'd4096;

    // atan(2^-i) in Q0.30
    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/four_wheel_steering_mixer.sv
// ----------------------------------------------------------------------------
// four_wheel_steering_mixer
// Velocity command to four-wheel steering angles and drive speed.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one beat per control tick carrying the velocity command.
//   m_* stream: zero or one result beat per command (steering or rotate).
//   APB port: angle_limit, speed_gain, wheel_base, joypad_hold registers.
// Sequence (input beat to result valid):
//   crab mode     2 squares, 16 root steps, round, multiply, 28 CORDIC steps,
//                 final
//   counter-steer speed multiply, yaw multiply, 28 CORDIC steps, final;
//                 zero yaw or a zero yaw product skips straight to final
//   rotate / idle command: final state only
//   The single shift-add CORDIC datapath and the shared 18x17 multiplier set
//   these sequences; s_tready is high only in IDLE, so one command is in
//   flight at a time and the next beat can be taken while the result is valid.
// Reset: registers return to defaults, held angles clear to zero.
// Stalls: the result sits in an output register; the next command can be
//   taken and processed meanwhile, and waits in its final state until the
//   output register frees up.
// Dropped beats: joypad hold, or spin requested while rotation not allowed.
// ----------------------------------------------------------------------------
module four_wheel_steering_mixer
(
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // forward_vel, lateral_vel, spin_vel, yaw_rate
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // drive_speed, front_angle, rear_angle, rotate_rate
    output logic        m_tuser    // command_kind
);

    // ---------------- configuration ----------------
    logic [13:0] angle_limit_reg;
    logic [15:0] speed_gain_reg;
    logic [15:0] wheel_base_reg;
    logic        joypad_hold_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_limit_reg <= fwsm_pkg::ANGLE_LIMIT_RST;
            speed_gain_reg  <= fwsm_pkg::SPEED_GAIN_RST;
            wheel_base_reg  <= fwsm_pkg::WHEEL_BASE_RST;
            joypad_hold_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (fwsm_pkg::reg_idx_t'(paddr[3:2]))
                fwsm_pkg::REG_ANGLE_LIMIT: angle_limit_reg <= pwdata[13:0];
                fwsm_pkg::REG_SPEED_GAIN:  speed_gain_reg  <= pwdata[15:0];
                fwsm_pkg::REG_WHEEL_BASE:  wheel_base_reg  <= pwdata[15:0];
                fwsm_pkg::REG_JOYPAD_HOLD: joypad_hold_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (fwsm_pkg::reg_idx_t'(paddr[3:2]))
            fwsm_pkg::REG_ANGLE_LIMIT: prdata = {18'd0, angle_limit_reg};
            fwsm_pkg::REG_SPEED_GAIN:  prdata = {16'd0, speed_gain_reg};
            fwsm_pkg::REG_WHEEL_BASE:  prdata = {16'd0, wheel_base_reg};
            fwsm_pkg::REG_JOYPAD_HOLD: prdata = {31'd0, joypad_hold_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- datapath registers ----------------
    fwsm_pkg::state_t state_reg, state_next;
    fwsm_pkg::mode_t  mode_reg, mode_next;

    logic signed [15:0] fwd_reg, fwd_next;
    logic signed [15:0] lat_reg, lat_next;
    logic signed [15:0] spin_reg, spin_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        sq_reg, sq_next;
    logic [31:0]        op_reg, op_next;
    logic [32:0]        res_reg, res_next;
    logic [31:0]        one_reg, one_next;
    logic signed [51:0] x_reg, x_next;
    logic signed [51:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic               zero_reg, zero_next;
    logic signed [31:0] speed_reg, speed_next;
    logic signed [14:0] held_front_reg, held_front_next;
    logic signed [14:0] held_rear_reg, held_rear_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic signed [31:0] out_speed_reg, out_speed_next;
    logic signed [14:0] out_front_reg, out_front_next;
    logic signed [14:0] out_rear_reg, out_rear_next;
    logic signed [15:0] out_rot_reg, out_rot_next;

    // ---------------- combinational helpers ----------------
    logic signed [15:0] in_fwd, in_lat, in_spin, in_yaw;
    logic               neg;
    logic signed [16:0] fwd17, lat17, afwd17, slat17;
    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] prod;
    logic signed [35:0] prod_s;
    logic signed [35:0] sp36;
    logic signed [31:0] sp_sat;
    logic [32:0]        root_sum;
    logic               root_ge;
    logic signed [51:0] xs, ys;
    logic signed [32:0] atan_t;
    logic signed [33:0] rsum;
    logic signed [17:0] r18, rc18, lim18, ang18;
    logic signed [14:0] ang;
    logic               out_free;

    assign in_fwd  = s_tdata[15:0];
    assign in_lat  = s_tdata[31:16];
    assign in_spin = s_tdata[47:32];
    assign in_yaw  = s_tdata[63:48];

    assign neg    = fwd_reg[15];
    assign fwd17  = {fwd_reg[15], fwd_reg};
    assign lat17  = {lat_reg[15], lat_reg};
    assign afwd17 = neg ? -fwd17 : fwd17;
    assign slat17 = neg ? -lat17 : lat17;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            fwsm_pkg::S_SQA:
            begin
                mul_a = {{2{fwd_reg[15]}}, fwd_reg};
                mul_b = fwd17;
            end
            fwsm_pkg::S_SQB:
            begin
                mul_a = {{2{lat_reg[15]}}, lat_reg};
                mul_b = lat17;
            end
            fwsm_pkg::S_SPD:
            begin
                mul_a = (mode_reg == fwsm_pkg::MODE_CRAB) ? {1'b0, res_reg[16:0]}
                                                          : {{2{fwd_reg[15]}}, fwd_reg};
                mul_b = {1'b0, speed_gain_reg};
            end
            fwsm_pkg::S_YAW:
            begin
                mul_a = {{2{yaw_reg[15]}}, yaw_reg};
                mul_b = {1'b0, wheel_base_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_s = {prod[34], prod};

    // signed speed with saturation
    assign sp36 = (mode_reg == fwsm_pkg::MODE_CRAB && neg) ? -prod_s : prod_s;
    always_comb
    begin
        if (sp36 > 36'sd2147483647)
            sp_sat = 32'sh7FFFFFFF;
        else if (sp36 < -36'sd2147483648)
            sp_sat = 32'sh80000000;
        else
            sp_sat = sp36[31:0];
    end

    // square root step
    assign root_sum = res_reg + {1'b0, one_reg};
    assign root_ge  = {1'b0, op_reg} >= root_sum;

    // CORDIC step
    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_t = {3'b000, fwsm_pkg::atan_lut(cnt_reg)};

    // angle rounding and clamping
    assign rsum  = {z_reg[32], z_reg} + 34'sd65536;
    assign r18   = {rsum[33], rsum[33:17]};
    assign lim18 = {4'b0000, angle_limit_reg};
    always_comb
    begin
        if (r18 > fwsm_pkg::ANGLE_MAX)
            rc18 = fwsm_pkg::ANGLE_MAX;
        else if (r18 < -fwsm_pkg::ANGLE_MAX)
            rc18 = -fwsm_pkg::ANGLE_MAX;
        else
            rc18 = r18;
        if (zero_reg)
            ang18 = '0;
        else if (rc18 > lim18)
            ang18 = lim18;
        else if (rc18 < -lim18)
            ang18 = -lim18;
        else
            ang18 = rc18;
    end
    assign ang = ang18[14:0];

    assign out_free = !out_valid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        fwd_next        = fwd_reg;
        lat_next        = lat_reg;
        spin_next       = spin_reg;
        yaw_next        = yaw_reg;
        cnt_next        = cnt_reg;
        sq_next         = sq_reg;
        op_next         = op_reg;
        res_next        = res_reg;
        one_next        = one_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        zero_next       = zero_reg;
        speed_next      = speed_reg;
        held_front_next = held_front_reg;
        held_rear_next  = held_rear_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_speed_next  = out_speed_reg;
        out_front_next  = out_front_reg;
        out_rear_next   = out_rear_reg;
        out_rot_next    = out_rot_reg;

        case (state_reg)
            fwsm_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    fwd_next   = in_fwd;
                    lat_next   = in_lat;
                    spin_next  = in_spin;
                    yaw_next   = in_yaw;
                    zero_next  = 1'b0;
                    speed_next = '0;
                    if (joypad_hold_reg)
                        state_next = fwsm_pkg::S_IDLE;
                    else if (in_lat != 0 && in_yaw == 0 && in_spin == 0)
                    begin
                        mode_next  = fwsm_pkg::MODE_CRAB;
                        state_next = fwsm_pkg::S_SQA;
                    end
                    else if (in_fwd != 0 && in_spin == 0)
                    begin
                        mode_next  = fwsm_pkg::MODE_STEER;
                        state_next = fwsm_pkg::S_SPD;
                    end
                    else if (in_spin != 0 && in_fwd == 0 && in_lat == 0
                             && held_front_reg == 0)
                    begin
                        mode_next  = fwsm_pkg::MODE_ROTATE;
                        state_next = fwsm_pkg::S_DONE;
                    end
                    else if (in_spin == 0)
                    begin
                        mode_next  = fwsm_pkg::MODE_HOLD;
                        state_next = fwsm_pkg::S_DONE;
                    end
                end
            end
            fwsm_pkg::S_SQA:
            begin
                sq_next    = prod[31:0];
                state_next = fwsm_pkg::S_SQB;
            end
            fwsm_pkg::S_SQB:
            begin
                op_next    = sq_reg + prod[31:0];
                res_next   = '0;
                one_next   = 32'h4000_0000;
                state_next = fwsm_pkg::S_ROOT;
            end
            fwsm_pkg::S_ROOT:
            begin
                if (root_ge)
                begin
                    op_next  = op_reg - root_sum[31:0];
                    res_next = (res_reg >> 1) + {1'b0, one_reg};
                end
                else
                    res_next = res_reg >> 1;
                one_next = one_reg >> 2;
                if (one_reg == 32'd1)
                    state_next = fwsm_pkg::S_RND;
            end
            fwsm_pkg::S_RND:
            begin
                if ({1'b0, op_reg} > res_reg)
                    res_next = res_reg + 33'd1;
                state_next = fwsm_pkg::S_SPD;
            end
            fwsm_pkg::S_SPD:
            begin
                speed_next = sp_sat;
                cnt_next   = '0;
                z_next     = '0;
                if (mode_reg == fwsm_pkg::MODE_CRAB)
                begin
                    x_next     = {19'd0, afwd17, 16'd0};
                    y_next     = {{19{slat17[16]}}, slat17, 16'd0};
                    state_next = fwsm_pkg::S_ROT;
                end
                else if (yaw_reg == 0)
                begin
                    zero_next  = 1'b1;
                    state_next = fwsm_pkg::S_DONE;
                end
                else
                    state_next = fwsm_pkg::S_YAW;
            end
            fwsm_pkg::S_YAW:
            begin
                x_next = {7'd0, afwd17, 28'd0};
                y_next = {(neg ? -prod_s : prod_s), 16'd0};
                if (prod == 0)
                begin
                    zero_next  = 1'b1;
                    state_next = fwsm_pkg::S_DONE;
                end
                else
                    state_next = fwsm_pkg::S_ROT;
            end
            fwsm_pkg::S_ROT:
            begin
                if (!y_reg[51] && y_reg != 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_t;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_t;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(fwsm_pkg::CORDIC_ITERS - 1))
                    state_next = fwsm_pkg::S_DONE;
            end
            fwsm_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (mode_reg == fwsm_pkg::MODE_ROTATE);
                    out_rot_next   = (mode_reg == fwsm_pkg::MODE_ROTATE) ? spin_reg : '0;
                    out_speed_next = speed_reg;
                    out_front_next = held_front_reg;
                    out_rear_next  = held_rear_reg;
                    if (mode_reg == fwsm_pkg::MODE_CRAB)
                    begin
                        held_front_next = ang;
                        held_rear_next  = ang;
                        out_front_next  = ang;
                        out_rear_next   = ang;
                    end
                    else if (mode_reg == fwsm_pkg::MODE_STEER)
                    begin
                        held_front_next = ang;
                        held_rear_next  = -ang;
                        out_front_next  = ang;
                        out_rear_next   = -ang;
                    end
                    state_next = fwsm_pkg::S_IDLE;
                end
            end
            default:
                state_next = fwsm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fwsm_pkg::S_IDLE;
            mode_reg       <= fwsm_pkg::MODE_HOLD;
            held_front_reg <= '0;
            held_rear_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            held_front_reg <= held_front_next;
            held_rear_reg  <= held_rear_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg       <= fwd_next;
        lat_reg       <= lat_next;
        spin_reg      <= spin_next;
        yaw_reg       <= yaw_next;
        cnt_reg       <= cnt_next;
        sq_reg        <= sq_next;
        op_reg        <= op_next;
        res_reg       <= res_next;
        one_reg       <= one_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        zero_reg      <= zero_next;
        speed_reg     <= speed_next;
        out_kind_reg  <= out_kind_next;
        out_speed_reg <= out_speed_next;
        out_front_reg <= out_front_next;
        out_rear_reg  <= out_rear_next;
        out_rot_reg   <= out_rot_next;
    end

    assign s_tready = (state_reg == fwsm_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_rot_reg, out_rear_reg, out_front_reg, out_speed_reg};

    // ---------------- assertions ----------------
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fwsm_pkg::S_DONE))
        else $error("result loaded outside final state");

    a_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
        held_rear_reg == held_front_reg || held_rear_reg == -held_front_reg)
        else $error("held angles out of step");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_front_reg <= 15'sd12868 && held_front_reg >= -15'sd12868)
        else $error("held angle beyond range");

    a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fwsm_pkg::S_ROT |-> cnt_reg < 5'(fwsm_pkg::CORDIC_ITERS))
        else $error("CORDIC step count overrun");

endmodule
